>>> src/oat_pkg.sv
// ----------------------------------------------------------------------------
// Outstanding allocation tracker package
// Shared types, codes and constants for the tracker's front, queue and back.
// ----------------------------------------------------------------------------
package oat_pkg;

  // Fixed field widths of the request and response items
  localparam int unsigned ADDR_FIELD_W = 48;
  localparam int unsigned SIZE_W       = 32;
  localparam int unsigned TOTAL_W      = 40;
  localparam int unsigned COUNT_OUT_W  = 7;

  // Defaults for the top-level parameters
  localparam int unsigned TABLE_DEPTH_DEF   = 64;
  localparam int unsigned ADDRESS_WIDTH_DEF = 48;

  // Request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Function codes on the request side
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Register index on the configuration port (paddr bit 2)
  localparam logic REG_TRACK_EN = 1'b0;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_IGNORED   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_CLEAR,
    OP_IGNORE
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_RESP
  } state_e;

  // Classified request as it travels through the queue
  typedef struct packed {
    op_e                     op;
    logic [ADDR_FIELD_W-1:0] addr;
    logic [SIZE_W-1:0]       size;
  } req_t;

  // Configuration write toward the back
  typedef struct packed {
    logic valid;
    logic enable;
  } cfg_wr_t;

  // Number of address bits that are kept and compared
  function automatic int unsigned addr_keep_w(int unsigned aw);
    return (aw < ADDR_FIELD_W) ? aw : ADDR_FIELD_W;
  endfunction

endpackage

>>> src/outstanding_allocation_tracker.sv
// ----------------------------------------------------------------------------
// Outstanding allocation tracker
// Table of live allocations with a saturating running byte total.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis group: tuser carries func (allocate, free,
//   clear), tdata the block address and size. Each request yields exactly
//   one response on the m_axis group: tuser holds the status, tdata the
//   active flag, the entry count and the outstanding byte total after it.
//   Tracking is turned on through the APB register tracking_enable; writing
//   1 also clears a latched table-full error. Write it only while idle.
// Operation:
//   A request lands in a two-entry queue, from which the back takes it when
//   idle. Allocate, clear and ignored requests go straight to the response
//   register. A free scans the entry table one entry per cycle through the
//   single read port of the table memory and, on a hit, moves the last entry
//   into the freed slot before it responds. One request is executed at a time.
// Reset and stall:
//   Reset empties the table, zeroes the total, clears the error and turns
//   tracking off. No clearing pass is needed; slots past the count are dead.
//   A stalled response holds in the output register while the queue keeps
//   taking requests until it fills; then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module outstanding_allocation_tracker #(
  parameter int unsigned TABLE_DEPTH   = oat_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ADDRESS_WIDTH = oat_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,   // block_address[47:0], block_size[79:48]
  input  logic [1:0]  s_axis_tuser_i,   // func[1:0]
  // Response stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // active[0], entry_count[7:1],
                                        // outstanding_total[47:8]
  output logic [1:0]  m_axis_tuser_o,   // status[1:0]
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  oat_pkg::req_t    front_req, queue_req;
  oat_pkg::cfg_wr_t cfg_wr;
  oat_pkg::stat_e   out_status;
  logic             push, q_full, q_valid, pop;
  logic             track_en;
  logic             out_active;
  logic [oat_pkg::COUNT_OUT_W-1:0] out_count;
  logic [oat_pkg::TOTAL_W-1:0]     out_total;

  // Configuration port: single register, no wait states
  assign pready        = 1'b1;
  assign cfg_wr.valid  = psel & penable & pwrite & (paddr[2] == oat_pkg::REG_TRACK_EN);
  assign cfg_wr.enable = pwdata[0];
  assign prdata        = (paddr[2] == oat_pkg::REG_TRACK_EN) ? {31'b0, track_en} : '0;

  // Classify incoming requests
  oat_front #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .req_o           (front_req)
  );

  // Buffer requests so the front keeps accepting during a long scan
  oat_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (front_req),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .req_o   (queue_req)
  );

  // Execute requests against the table and drive the response register
  oat_back #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_req_i      (queue_req),
    .pop_o        (pop),
    .cfg_wr_i     (cfg_wr),
    .enable_o     (track_en),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_active_o (out_active),
    .out_count_o  (out_count),
    .out_total_o  (out_total)
  );

  // Pack the response
  assign m_axis_tuser_o = out_status;
  assign m_axis_tdata_o = {out_total, out_count, out_active};

endmodule

>>> src/oat_front.sv
// ----------------------------------------------------------------------------
// Tracker front
// Accepts requests, masks the address and classifies each into an operation.
// ----------------------------------------------------------------------------
module oat_front #(
  parameter int unsigned ADDRESS_WIDTH = oat_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [79:0]   s_axis_tdata_i,  // block_address[47:0], block_size[79:48]
  input  logic [1:0]    s_axis_tuser_i,  // func[1:0]
  input  logic          q_full_i,
  output logic          push_o,
  output oat_pkg::req_t req_o
);

  localparam int unsigned KeepW = oat_pkg::addr_keep_w(ADDRESS_WIDTH);
  localparam logic [oat_pkg::ADDR_FIELD_W-1:0] AddrMask =
    (KeepW >= oat_pkg::ADDR_FIELD_W) ? {oat_pkg::ADDR_FIELD_W{1'b1}}
                                     : ((oat_pkg::ADDR_FIELD_W'(1) << KeepW) - 1'b1);

  logic [oat_pkg::ADDR_FIELD_W-1:0] addr;
  logic                             null_addr;

  assign addr      = s_axis_tdata_i[oat_pkg::ADDR_FIELD_W-1:0] & AddrMask;
  assign null_addr = (addr == '0);

  assign s_axis_tready_o = ~q_full_i;
  assign push_o          = s_axis_tvalid_i & ~q_full_i;

  always_comb begin
    req_o.addr = addr;
    req_o.size = s_axis_tdata_i[79:48];
    case (s_axis_tuser_i)
      oat_pkg::FUNC_ALLOC: req_o.op = null_addr ? oat_pkg::OP_IGNORE : oat_pkg::OP_ALLOC;
      oat_pkg::FUNC_FREE:  req_o.op = null_addr ? oat_pkg::OP_IGNORE : oat_pkg::OP_FREE;
      oat_pkg::FUNC_CLEAR: req_o.op = oat_pkg::OP_CLEAR;
      default:             req_o.op = oat_pkg::OP_IGNORE;
    endcase
  end

endmodule

>>> src/oat_queue.sv
// ----------------------------------------------------------------------------
// Tracker request queue
// Short FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module oat_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  oat_pkg::req_t req_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output oat_pkg::req_t req_o
);

  oat_pkg::req_t                entries_q [oat_pkg::QUEUE_DEPTH];
  logic [oat_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [oat_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [oat_pkg::QCNT_W-1:0]   cnt_q, cnt_d;
  logic                         do_push, do_pop;

  localparam logic [oat_pkg::QPTR_W-1:0] LastPtr = oat_pkg::QPTR_W'(oat_pkg::QUEUE_DEPTH - 1);

  assign full_o  = (cnt_q == oat_pkg::QCNT_W'(oat_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign req_o   = entries_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

>>> src/oat_back.sv
// ----------------------------------------------------------------------------
// Tracker back
// Executes requests against the entry table, keeps count, total and error,
// and holds the response register.
// ----------------------------------------------------------------------------
module oat_back #(
  parameter int unsigned TABLE_DEPTH   = oat_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ADDRESS_WIDTH = oat_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  oat_pkg::req_t                     q_req_i,
  output logic                              pop_o,
  input  oat_pkg::cfg_wr_t                  cfg_wr_i,
  output logic                              enable_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output oat_pkg::stat_e                    out_status_o,
  output logic                              out_active_o,
  output logic [oat_pkg::COUNT_OUT_W-1:0]   out_count_o,
  output logic [oat_pkg::TOTAL_W-1:0]       out_total_o
);

  localparam int unsigned KeepW = oat_pkg::addr_keep_w(ADDRESS_WIDTH);
  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WordW = KeepW + oat_pkg::SIZE_W;
  localparam int unsigned TotW  = oat_pkg::TOTAL_W;

  // Entry table: {address, size} per slot
  logic [WordW-1:0] entry_mem [TABLE_DEPTH];
  logic [WordW-1:0] rdata_q;
  logic [IdxW-1:0]  mem_raddr, mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic             mem_we;

  oat_pkg::state_e          state_q, state_d;
  oat_pkg::req_t            req_q, req_d;
  oat_pkg::stat_e           stat_q, stat_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [TotW-1:0]          total_q, total_d;
  logic                     err_q, err_d;
  logic                     en_q, en_d;
  logic [IdxW-1:0]          cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]          hit_idx_q, hit_idx_d;
  logic [oat_pkg::SIZE_W-1:0] size_q, size_d;
  logic                     out_valid_q, out_valid_d;
  oat_pkg::stat_e           out_status_q, out_status_d;
  logic                     out_active_q, out_active_d;
  logic [oat_pkg::COUNT_OUT_W-1:0] out_count_q, out_count_d;
  logic [TotW-1:0]          out_total_q, out_total_d;

  logic             active;
  logic             table_full;
  logic [IdxW-1:0]  last_idx;
  logic             hit;
  logic             scan_end;
  logic             out_free;
  logic [TotW:0]    sum;

  assign active     = en_q & ~err_q;
  assign table_full = (count_q == CntW'(TABLE_DEPTH));
  assign last_idx   = IdxW'(count_q - CntW'(1));
  assign hit        = (rdata_q[WordW-1:oat_pkg::SIZE_W] == req_q.addr[KeepW-1:0]);
  assign scan_end   = (cmp_idx_q == last_idx);
  assign out_free   = ~out_valid_q | out_ready_i;
  assign sum        = {1'b0, total_q} + (TotW + 1)'(q_req_i.size);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      oat_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          if (q_req_i.op == oat_pkg::OP_FREE && active && count_q != '0) begin
            state_d = oat_pkg::ST_SCAN;
          end else begin
            state_d = oat_pkg::ST_RESP;
          end
        end
      end
      oat_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = oat_pkg::ST_LAST;
        end else if (scan_end) begin
          state_d = oat_pkg::ST_RESP;
        end
      end
      oat_pkg::ST_LAST: state_d = oat_pkg::ST_RESP;
      oat_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = oat_pkg::ST_IDLE;
        end
      end
      default: state_d = oat_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    req_d        = req_q;
    stat_d       = stat_q;
    count_d      = count_q;
    total_d      = total_q;
    err_d        = err_q;
    en_d         = en_q;
    cmp_idx_d    = cmp_idx_q;
    hit_idx_d    = hit_idx_q;
    size_d       = size_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_status_d = out_status_q;
    out_active_d = out_active_q;
    out_count_d  = out_count_q;
    out_total_d  = out_total_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = '0;
    pop_o        = 1'b0;

    case (state_q)
      oat_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          pop_o     = 1'b1;
          req_d     = q_req_i;
          cmp_idx_d = '0;
          case (q_req_i.op)
            oat_pkg::OP_CLEAR: begin
              count_d = '0;
              total_d = '0;
              err_d   = 1'b0;
              stat_d  = oat_pkg::STAT_DONE;
            end
            oat_pkg::OP_ALLOC: begin
              if (!active) begin
                stat_d = oat_pkg::STAT_IGNORED;
              end else if (table_full) begin
                err_d  = 1'b1;
                en_d   = 1'b0;
                stat_d = oat_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = IdxW'(count_q);
                mem_wdata = {q_req_i.addr[KeepW-1:0], q_req_i.size};
                count_d   = count_q + CntW'(1);
                total_d   = sum[TotW] ? {TotW{1'b1}} : sum[TotW-1:0];
                stat_d    = oat_pkg::STAT_DONE;
              end
            end
            oat_pkg::OP_FREE: begin
              if (!active) begin
                stat_d = oat_pkg::STAT_IGNORED;
              end else if (count_q == '0) begin
                stat_d = oat_pkg::STAT_NOT_FOUND;
              end
            end
            default: stat_d = oat_pkg::STAT_IGNORED;
          endcase
        end
      end
      oat_pkg::ST_SCAN: begin
        // Compare the entry read last cycle; fetch the next one, or the last entry on a hit
        if (hit) begin
          hit_idx_d = cmp_idx_q;
          size_d    = rdata_q[oat_pkg::SIZE_W-1:0];
          mem_raddr = last_idx;
        end else if (scan_end) begin
          stat_d = oat_pkg::STAT_NOT_FOUND;
        end else begin
          mem_raddr = cmp_idx_q + 1'b1;
          cmp_idx_d = cmp_idx_q + 1'b1;
        end
      end
      oat_pkg::ST_LAST: begin
        // Move the last entry into the freed slot
        mem_we    = 1'b1;
        mem_waddr = hit_idx_q;
        mem_wdata = rdata_q;
        count_d   = count_q - CntW'(1);
        total_d   = (total_q >= TotW'(size_q)) ? total_q - TotW'(size_q) : '0;
        stat_d    = oat_pkg::STAT_DONE;
      end
      oat_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = stat_q;
          out_active_d = active;
          out_count_d  = oat_pkg::COUNT_OUT_W'(count_q);
          out_total_d  = total_q;
        end
      end
      default: ;
    endcase

    if (cfg_wr_i.valid) begin
      en_d = cfg_wr_i.enable;
      if (cfg_wr_i.enable) begin
        err_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oat_pkg::ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      err_q       <= 1'b0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      err_q       <= err_d;
      en_q        <= en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    stat_q       <= stat_d;
    cmp_idx_q    <= cmp_idx_d;
    hit_idx_q    <= hit_idx_d;
    size_q       <= size_d;
    out_status_q <= out_status_d;
    out_active_q <= out_active_d;
    out_count_q  <= out_count_d;
    out_total_q  <= out_total_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= entry_mem[mem_raddr];
  end

  assign enable_o     = en_q;
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_active_o = out_active_q;
  assign out_count_o  = out_count_q;
  assign out_total_o  = out_total_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oat_pkg::ST_SCAN) |-> (CntW'(cmp_idx_q) < count_q))
    else $error("scan index past live entries");

  a_err_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> !en_q)
    else $error("error latched while tracking enabled");

  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oat_pkg::ST_RESP && out_free) |=> out_valid_q)
    else $error("response not loaded on leaving response state");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Outstanding allocation tracker testbench
// Drives allocate, free, clear and unused requests into the tracker, predicts
// each response from a behavioral copy of the table, total and error flag,
// and checks every response field. Tracking enable is written over APB
// between phases while the block is idle. Both streams idle at random, and
// the response side holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned TRACK_DEPTH    = oat_pkg::TABLE_DEPTH_DEF;
  localparam int          ITEM_TARGET    = 1450; // requests queued over the whole run
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_AT        = 300;  // responses retired before the hold-off
  localparam int          HOLD_LEN       = 600;  // cycles of hold-off
  localparam int          DRAIN_CYCLES   = 80;   // longer than a free over a full table

  localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
  localparam logic [2:0]  TRACK_EN_ADDR  = {oat_pkg::REG_TRACK_EN, 2'b00};

  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] addr;
    logic [31:0] size;
  } req_item_t;

  typedef struct packed {
    oat_pkg::stat_e status;
    logic           active;
    logic [6:0]     count;
    logic [39:0]    total;
  } resp_item_t;

  typedef enum int {PH_MIX, PH_FILL, PH_POOL} phase_kind_e;

  // Clock, reset and DUT ports; every input starts at a known value
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [79:0] s_tdata = '0;   // block_address[47:0], block_size[79:48]
  logic [1:0]  s_tuser = '0;   // func[1:0]
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic [47:0] m_axis_tdata_o; // active[0], entry_count[7:1], outstanding_total[47:8]
  logic [1:0]  m_axis_tuser_o; // status[1:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #2 clk_i = ~clk_i;

  outstanding_allocation_tracker #(
    .TABLE_DEPTH  (TRACK_DEPTH),
    .ADDRESS_WIDTH(oat_pkg::ADDRESS_WIDTH_DEF)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // Predicted tracker state, advanced at request acceptance
  // --------------------------------------------------------------------------
  logic [47:0] tbl_addr [TRACK_DEPTH];
  logic [31:0] tbl_size [TRACK_DEPTH];
  int unsigned live_n   = 0;
  logic [39:0] byte_sum = '0;
  logic        err_flag = 1'b0;
  logic        track_en = 1'b0;

  // Requests waiting for the driver, and responses owed by the block
  req_item_t   pending[$];
  resp_item_t  owed_resp[$];

  int n_queued   = 0;  // requests handed to the driver
  int n_accepted = 0;  // requests taken by the block
  int n_retired  = 0;  // responses taken from the block
  int n_faults   = 0;

  // Stimulus-side view of the table, used only to aim frees at live entries
  logic [47:0] gen_live[$];
  logic        gen_en  = 1'b0;
  logic        gen_err = 1'b0;

  // Apply one request to the predicted state and return its response
  function automatic resp_item_t track_request(req_item_t r);
    resp_item_t o;
    int         hit;
    logic [40:0] sum;
    hit = -1;
    o.status = oat_pkg::STAT_DONE;
    if (r.func == oat_pkg::FUNC_CLEAR) begin
      live_n   = 0;
      byte_sum = '0;
      err_flag = 1'b0;
    end else if (r.func == FUNC_UNUSED || !(track_en && !err_flag) || r.addr == '0) begin
      o.status = oat_pkg::STAT_IGNORED;
    end else if (r.func == oat_pkg::FUNC_ALLOC) begin
      if (live_n >= TRACK_DEPTH) begin
        // table full: latch the error and drop tracking, table untouched
        err_flag = 1'b1;
        track_en = 1'b0;
        o.status = oat_pkg::STAT_FULL;
      end else begin
        tbl_addr[live_n] = r.addr;
        tbl_size[live_n] = r.size;
        live_n++;
        sum = {1'b0, byte_sum} + 41'(r.size);
        byte_sum = sum[40] ? '1 : sum[39:0];
      end
    end else begin
      // first matching entry wins; the last entry moves into its slot
      for (int i = 0; i < int'(live_n); i++)
        if (hit < 0 && tbl_addr[i] == r.addr) hit = i;
      if (hit < 0) begin
        o.status = oat_pkg::STAT_NOT_FOUND;
      end else begin
        byte_sum = (byte_sum >= 40'(tbl_size[hit])) ? byte_sum - 40'(tbl_size[hit]) : '0;
        tbl_addr[hit] = tbl_addr[live_n - 1];
        tbl_size[hit] = tbl_size[live_n - 1];
        live_n--;
      end
    end
    o.active = track_en && !err_flag;
    o.count  = live_n[6:0];
    o.total  = byte_sum;
    return o;
  endfunction

  function automatic void log_fault(string msg);
    if (n_faults < 10) $display("mismatch: %s", msg);
    n_faults++;
  endfunction

  // Gap length in cycles: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: present the next pending request at the falling edge
  // --------------------------------------------------------------------------
  logic s_fire_q = 1'b0;
  int   s_gap    = 0;
  int   s_calm   = 0;

  always @(negedge clk_i) begin
    req_item_t nxt;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_fire_q) begin
      if (s_gap > 0) begin
        s_gap   = s_gap - 1;
        s_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        nxt = pending.pop_front();
        s_tuser <= nxt.func;
        s_tdata <= {nxt.size, nxt.addr};
        s_valid <= 1'b1;
        // run without gaps for a stretch now and then
        if (s_calm > 0) s_calm = s_calm - 1;
        else if ($urandom_range(0, 39) == 0) s_calm = 100;
        s_gap = (s_calm > 0) ? 0 : gap_len();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response ready: random stalls, calm stretches and one long hold-off
  // --------------------------------------------------------------------------
  int   m_stall   = 0;
  int   m_calm    = 0;
  int   hold_left = 0;
  logic held_once = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_ready <= 1'b0;
    end else if (!held_once && n_retired >= HOLD_AT && n_queued - n_retired >= 20) begin
      // hold off while plenty of requests are still queued so the input stalls
      held_once = 1'b1;
      hold_left = HOLD_LEN;
      m_ready <= 1'b0;
    end else if (m_stall > 0) begin
      m_stall = m_stall - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      if (m_calm > 0) m_calm = m_calm - 1;
      else if ($urandom_range(0, 199) == 0) m_calm = 150;
      m_stall = (m_calm > 0 || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on request acceptance, check on response acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    req_item_t  taken;
    resp_item_t want;
    resp_item_t got;
    s_fire_q <= rst_ni && s_valid && s_axis_tready_o;
    if (rst_ni && s_valid && s_axis_tready_o) begin
      taken.func = s_tuser;
      taken.addr = s_tdata[47:0];
      taken.size = s_tdata[79:48];
      owed_resp = {owed_resp, track_request(taken)};
      n_accepted <= n_accepted + 1;
    end
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got.status = oat_pkg::stat_e'(m_axis_tuser_o);
      got.active = m_axis_tdata_o[0];
      got.count  = m_axis_tdata_o[7:1];
      got.total  = m_axis_tdata_o[47:8];
      if (owed_resp.size() == 0) begin
        log_fault($sformatf("response with none owed: status %0d count %0d total %0h",
                            got.status, got.count, got.total));
      end else begin
        want = owed_resp.pop_front();
        if (got.status !== want.status || got.active !== want.active ||
            got.count !== want.count || got.total !== want.total)
          log_fault($sformatf(
            "response %0d: status %0d/%0d active %0d/%0d count %0d/%0d total %0h/%0h",
            n_retired, want.status, got.status, want.active, got.active,
            want.count, got.count, want.total, got.total));
      end
      n_retired <= n_retired + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither stream moves for too long
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Queue one request and advance the stimulus-side view of the table
  task automatic add_req(input logic [1:0] func, input logic [47:0] addr,
                         input logic [31:0] size);
    req_item_t r;
    int        hit;
    r.func = func;
    r.addr = addr;
    r.size = size;
    hit = -1;
    pending = {pending, r};
    n_queued++;
    if (func == oat_pkg::FUNC_CLEAR) begin
      gen_live.delete();
      gen_err = 1'b0;
    end else if (func != FUNC_UNUSED && gen_en && !gen_err && addr != '0) begin
      if (func == oat_pkg::FUNC_ALLOC) begin
        if (gen_live.size() >= TRACK_DEPTH) begin
          gen_err = 1'b1;
          gen_en  = 1'b0;
        end else begin
          gen_live = {gen_live, addr};
        end
      end else begin
        for (int i = 0; i < gen_live.size(); i++)
          if (hit < 0 && gen_live[i] == addr) hit = i;
        if (hit >= 0) gen_live.delete(hit);
      end
    end
  endtask

  // Wait until every queued request has been answered, then let the block settle
  task automatic settle();
    @(negedge clk_i);
    while (n_accepted != n_queued || n_retired < n_accepted) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of tracking_enable: setup cycle, access cycle, then release
  task automatic write_track_en(input logic en);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = TRACK_EN_ADDR;
    pwdata  = {31'd0, en};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    // register takes the value at this edge
    track_en = en;
    if (en) err_flag = 1'b0;
    gen_en = en;
    if (en) gen_err = 1'b0;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_addr(phase_kind_e kind);
    logic [47:0] a;
    if (kind == PH_POOL) begin
      // few distinct addresses, both low and high, to force duplicates
      a = 48'($urandom_range(1, 12));
      if ($urandom_range(0, 1)) a = a << 40;
    end else if ($urandom_range(0, 19) == 0) begin
      a = '1;
    end else begin
      a = {16'($urandom), 32'($urandom)};
    end
    if (a == '0) a = 48'd1;
    return a;
  endfunction

  function automatic logic [31:0] rand_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // One phase of well-formed traffic with random content and some noise
  task automatic gen_phase(input phase_kind_e kind, input int n_items);
    int          pick;
    int          alloc_cut;
    logic [47:0] a;
    logic [1:0]  f;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      a    = rand_addr(kind);
      f    = oat_pkg::FUNC_ALLOC;
      if (kind == PH_FILL) alloc_cut = 92;
      else if (gen_live.size() > 48) alloc_cut = 45;
      else alloc_cut = 60;
      if (pick < 3) begin
        f = oat_pkg::FUNC_CLEAR;
      end else if (pick < 6) begin
        f = FUNC_UNUSED;
      end else if (pick < 10) begin
        // null address on allocate or free
        f = $urandom_range(0, 1) ? oat_pkg::FUNC_ALLOC : oat_pkg::FUNC_FREE;
        a = '0;
      end else if (pick < 16) begin
        f = oat_pkg::FUNC_FREE;
      end else if (pick < alloc_cut) begin
        if (gen_live.size() > 0 && $urandom_range(0, 9) == 0)
          a = gen_live[$urandom_range(0, gen_live.size() - 1)];
      end else if (gen_live.size() > 0) begin
        f = oat_pkg::FUNC_FREE;
        a = gen_live[$urandom_range(0, gen_live.size() - 1)];
      end
      add_req(f, a, rand_size());
      // a fill phase ends once the table has overflowed
      if (kind == PH_FILL && gen_err) break;
    end
  endtask

  initial begin
    phase_kind_e kind;
    logic        en;
    int          phase;
    int          phase_len;
    phase = 0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Tracking still off after reset: allocate and free are ignored, clear acts
    add_req(oat_pkg::FUNC_ALLOC, 48'd5, 32'd7);
    add_req(oat_pkg::FUNC_FREE, 48'd5, 32'd0);
    add_req(oat_pkg::FUNC_CLEAR, 48'd0, 32'd0);
    add_req(FUNC_UNUSED, 48'd5, 32'd7);
    settle();
    write_track_en(1'b1);

    // Field extremes, null address, duplicates, free not found, last-entry move
    add_req(oat_pkg::FUNC_ALLOC, '1, '1);
    add_req(oat_pkg::FUNC_ALLOC, 48'd1, 32'd0);
    add_req(oat_pkg::FUNC_ALLOC, 48'd0, 32'd100);
    add_req(oat_pkg::FUNC_FREE, 48'd0, 32'd0);
    add_req(oat_pkg::FUNC_ALLOC, 48'd1, 32'd1);
    add_req(oat_pkg::FUNC_FREE, 48'd2, 32'd0);
    add_req(oat_pkg::FUNC_FREE, 48'd1, 32'd0);
    add_req(oat_pkg::FUNC_FREE, '1, '1);
    add_req(oat_pkg::FUNC_FREE, 48'd1, 32'd0);
    add_req(oat_pkg::FUNC_FREE, 48'd1, 32'd0);
    add_req(FUNC_UNUSED, '1, '1);
    add_req(oat_pkg::FUNC_ALLOC, 48'h5555_5555_5555, 32'hAAAA_AAAA);
    add_req(oat_pkg::FUNC_ALLOC, 48'hAAAA_AAAA_AAAA, 32'h5555_5555);
    add_req(oat_pkg::FUNC_CLEAR, '1, '1);
    add_req(oat_pkg::FUNC_ALLOC, 48'd3, 32'd3);
    settle();

    // Turn tracking off with an entry live, then back on
    write_track_en(1'b0);
    add_req(oat_pkg::FUNC_ALLOC, 48'd4, 32'd4);
    add_req(oat_pkg::FUNC_FREE, 48'd3, 32'd0);
    settle();
    write_track_en(1'b1);

    // Random phases; a fill phase mostly allocates, to overflow the table and latch the error
    while (n_queued < ITEM_TARGET) begin
      case (phase % 4)
        0:       kind = PH_FILL;
        2:       kind = PH_POOL;
        default: kind = PH_MIX;
      endcase
      en = ($urandom_range(0, 6) != 0);
      phase_len = en ? $urandom_range(120, 200) : 15;
      if (phase_len > ITEM_TARGET - n_queued) phase_len = ITEM_TARGET - n_queued;
      settle();
      write_track_en(en);
      gen_phase(kind, phase_len);
      phase++;
    end

    // Drain, then allow for a last free over a full table
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (owed_resp.size() != 0) log_fault($sformatf("%0d responses never came", owed_resp.size()));
    if (n_faults == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
